// ----- rtl/core/hsp_pkg.sv -----
// Shared types and constants of the Hilbert scan point generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hsp_pkg;

   // Field and register widths
   localparam int POS_W       = 16;
   localparam int TARGET_W    = 16;
   localparam int ORDER_W     = 4;
   localparam int SCALE_W     = 8;
   localparam int PROD_W      = 24;
   localparam int MAX_ORDER_DEFAULT = 8;

   // Register reset values
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd5;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_ORDER = 1'b0;
   localparam logic CSR_IDX_SCALE = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_SCALE,
      ST_HOLD
   } hsp_state_type;

endpackage : hsp_pkg

`default_nettype wire

// ----- rtl/core/hsp_walk.sv -----
// Iterative index-to-point unit: one curve level per clock cycle.
// Depends on hsp_pkg.
`default_nettype none

module hsp_walk
   import hsp_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT,
   localparam int CW = MAX_ORDER,
   localparam int OW = $clog2(MAX_ORDER + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [OW-1:0] order,
   input  wire logic [POS_W-1:0] index,
   output logic               done,
   output logic [CW-1:0]      grid_x,
   output logic [CW-1:0]      grid_y
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [OW-1:0]     lvl_ff, lvl_in;
   logic [OW-1:0]     order_ff, order_in;
   logic [POS_W-1:0]  t_ff, t_in;
   logic [CW-1:0]     x_ff, x_in;
   logic [CW-1:0]     y_ff, y_in;

   logic [CW-1:0]     side;
   logic [CW-1:0]     side_mask;
   logic              rx;
   logic              ry;
   logic [CW-1:0]     x_flip;
   logic [CW-1:0]     y_flip;
   logic [CW-1:0]     x_rot;
   logic [CW-1:0]     y_rot;

   // Rotate and flip the partial point for the current level
   always_comb begin
      side      = CW'(1) << lvl_ff;
      side_mask = side - CW'(1);
      rx        = t_ff[1];
      ry        = t_ff[0] ^ t_ff[1];
      x_flip    = rx ? (side_mask - x_ff) : x_ff;
      y_flip    = rx ? (side_mask - y_ff) : y_ff;
      if (!ry) begin
         x_rot = y_flip;
         y_rot = x_flip;
      end else begin
         x_rot = x_ff;
         y_rot = y_ff;
      end
   end

   // Load on start, advance one level while busy
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      lvl_in   = lvl_ff;
      order_in = order_ff;
      t_in     = t_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      if (start) begin
         busy_in  = 1'b1;
         lvl_in   = '0;
         order_in = order;
         t_in     = index;
         x_in     = '0;
         y_in     = '0;
      end else if (busy_ff) begin
         x_in   = x_rot | (rx ? side : '0);
         y_in   = y_rot | (ry ? side : '0);
         t_in   = t_ff >> 2;
         lvl_in = lvl_ff + OW'(1);
         if (lvl_ff == order_ff - OW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      lvl_ff   <= lvl_in;
      order_ff <= order_in;
      t_ff     <= t_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
   end

   assign done   = done_ff;
   assign grid_x = x_ff;
   assign grid_y = y_ff;

endmodule : hsp_walk

`default_nettype wire

// ----- rtl/core/hsp_scale.sv -----
// Shared multiplier that scales the X then the Y grid coordinate.
// Depends on hsp_pkg.
`default_nettype none

module hsp_scale
   import hsp_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT,
   localparam int CW = MAX_ORDER
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [CW-1:0]      grid_x,
   input  wire logic [CW-1:0]      grid_y,
   input  wire logic [SCALE_W-1:0] scale,
   output logic                    done,
   output logic [TARGET_W-1:0]     target_x,
   output logic [TARGET_W-1:0]     target_y
);

   logic                busy_ff, busy_in;
   logic                sel_y_ff, sel_y_in;
   logic                done_ff, done_in;
   logic [TARGET_W-1:0] tx_ff, tx_in;
   logic [TARGET_W-1:0] ty_ff, ty_in;
   logic [CW-1:0]       operand;
   logic [PROD_W-1:0]   product;

   // One multiply per cycle, operand picked by the step
   always_comb begin
      operand = sel_y_ff ? grid_y : grid_x;
      product = PROD_W'(operand) * PROD_W'(scale);
   end

   // Step X, then Y, then report done
   always_comb begin
      busy_in  = busy_ff;
      sel_y_in = sel_y_ff;
      done_in  = 1'b0;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      if (start) begin
         busy_in  = 1'b1;
         sel_y_in = 1'b0;
      end else if (busy_ff) begin
         if (!sel_y_ff) begin
            tx_in    = product[TARGET_W-1:0];
            sel_y_in = 1'b1;
         end else begin
            ty_in   = product[TARGET_W-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         sel_y_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         sel_y_ff <= sel_y_in;
         done_ff  <= done_in;
      end
      tx_ff <= tx_in;
      ty_ff <= ty_in;
   end

   assign done     = done_ff;
   assign target_x = tx_ff;
   assign target_y = ty_ff;

endmodule : hsp_scale

`default_nettype wire

// ----- rtl/core/hilbert_scan_point_generator.sv -----
// Hilbert scan point generator. Each request carries the two axis-idle flags. A request
// with either axis busy is taken and gives no result. A request with both axes idle
// gives one result: the next point of a Hilbert curve of order curve_order (grid side
// 2^order, walk starting at (0,0)), each coordinate multiplied by coord_scale and kept
// to 16 bits, plus its index along the curve; the index then advances and wraps after
// 4^order points. Such a request passes through the level walk (one curve level per
// cycle), then the shared multiplier (X, then Y), then into the output register. The
// block takes no new request until the result is in the output register, but takes the
// next one while a finished result still waits in the output register.
// Depends on hsp_pkg, hsp_walk and hsp_scale.
`default_nettype none

module hilbert_scan_point_generator
   import hsp_pkg::*;
#(
   parameter int MAX_ORDER = MAX_ORDER_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_x_idle,
   input  wire logic                  req_y_idle,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [TARGET_W-1:0]        rsp_target_x,
   output logic [TARGET_W-1:0]        rsp_target_y,
   output logic [POS_W-1:0]           rsp_point_number,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int CW = MAX_ORDER;
   localparam int OW = $clog2(MAX_ORDER + 1);

   hsp_state_type       state_ff, state_in;
   logic [ORDER_W-1:0]  order_ff, order_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    num_ff, num_in;
   logic                out_valid_ff, out_valid_in;
   logic [TARGET_W-1:0] out_x_ff, out_x_in;
   logic [TARGET_W-1:0] out_y_ff, out_y_in;
   logic [POS_W-1:0]    out_num_ff, out_num_in;

   logic                csr_write;
   logic [OW-1:0]       eff_order;
   logic [POS_W-1:0]    index_mask;
   logic [POS_W-1:0]    index_now;
   logic                req_take;
   logic                req_point;
   logic                walk_done;
   logic                scale_start;
   logic                scale_done;
   logic                out_free;
   logic                out_load;
   logic [CW-1:0]       grid_x;
   logic [CW-1:0]       grid_y;
   logic [TARGET_W-1:0] scaled_x;
   logic [TARGET_W-1:0] scaled_y;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      order_in = order_ff;
      scale_in = scale_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_IDX_ORDER: order_in = pwdata[ORDER_W-1:0];
            CSR_IDX_SCALE: scale_in = pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_ORDER: prdata = CSR_DATA_W'(order_ff);
         CSR_IDX_SCALE: prdata = CSR_DATA_W'(scale_ff);
         default:       prdata = '0;
      endcase
   end

   // Clamp the order to 1..MAX_ORDER
   always_comb begin
      if (order_ff == '0) begin
         eff_order = OW'(1);
      end else if (int'(order_ff) > MAX_ORDER) begin
         eff_order = OW'(MAX_ORDER);
      end else begin
         eff_order = OW'(order_ff);
      end
   end

   // Index mask covers the low 2*order bits
   always_comb begin
      for (int i = 0; i < POS_W; i++) begin
         index_mask[i] = (i < 2 * int'(eff_order));
      end
   end

   assign index_now = pos_ff & index_mask;
   assign req_take  = req_valid & req_ready;
   assign req_point = req_take & req_x_idle & req_y_idle;
   assign out_free  = ~out_valid_ff | rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_point)  state_in = ST_WALK;
         ST_WALK:  if (walk_done)  state_in = ST_SCALE;
         ST_SCALE: if (scale_done) state_in = ST_HOLD;
         ST_HOLD:  if (out_free)   state_in = ST_IDLE;
         default:                  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      scale_start = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready   = 1'b1;
         ST_WALK:  scale_start = walk_done;
         ST_SCALE: ;
         ST_HOLD:  out_load    = out_free;
         default:  ;
      endcase
   end

   // Latch the index and advance the position on a point request
   always_comb begin
      pos_in = pos_ff;
      num_in = num_ff;
      if (req_point) begin
         num_in = index_now;
         pos_in = (index_now + POS_W'(1)) & index_mask;
      end
   end

   // Output register: load a finished point, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_num_in   = out_num_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         out_x_in     = scaled_x;
         out_y_in     = scaled_y;
         out_num_in   = num_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= ORDER_RESET;
         scale_ff     <= SCALE_RESET;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         scale_ff     <= scale_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      num_ff     <= num_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_num_ff <= out_num_in;
   end

   hsp_walk #(
      .MAX_ORDER (MAX_ORDER)
   ) u_walk (
      .clock  (clock),
      .reset  (reset),
      .start  (req_point),
      .order  (eff_order),
      .index  (index_now),
      .done   (walk_done),
      .grid_x (grid_x),
      .grid_y (grid_y)
   );

   hsp_scale #(
      .MAX_ORDER (MAX_ORDER)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (scale_start),
      .grid_x   (grid_x),
      .grid_y   (grid_y),
      .scale    (scale_ff),
      .done     (scale_done),
      .target_x (scaled_x),
      .target_y (scaled_y)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_target_x     = out_x_ff;
   assign rsp_target_y     = out_y_ff;
   assign rsp_point_number = out_num_ff;

endmodule : hilbert_scan_point_generator

`default_nettype wire

// ----- tb/tb_hilbert_scan_point_generator.sv -----
// Self-checking testbench for hilbert_scan_point_generator: directed table, then random polls.
// Predicts each curve point locally and compares every accepted result in order.
// Depends on hsp_pkg and the hilbert_scan_point_generator RTL.

module tb_hilbert_scan_point_generator;
   import hsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CURVE_ORDER_CAP = MAX_ORDER_DEFAULT;
   localparam int SETTLE_CYCLES   = 20;
   localparam int DRAIN_CYCLES    = 40;
   localparam int STALL_LIMIT     = 2000;
   localparam int POLLS_PER_PHASE = 45;

   typedef struct packed {
      logic [TARGET_W-1:0] x;
      logic [TARGET_W-1:0] y;
      logic [POS_W-1:0]    n;
   } point_type;

   typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_type;
   typedef enum logic {FROM_MODEL, TYPED_IN} row_check_type;

   typedef struct packed {
      row_kind_type          kind;
      row_check_type         check;
      logic                  x_idle;
      logic                  y_idle;
      logic                  reg_idx;
      logic [CSR_DATA_W-1:0] value;
      point_type             expected;
   } scan_row_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [SCALE_W-1:0] scale;
   } curve_setting_type;

   localparam point_type NO_POINT    = '0;
   localparam point_type FIRST_POINT = '{x: 16'd0, y: 16'd0, n: 16'd0};

   // clock, reset and block inputs, all known from time zero
   logic                  clock   = 1'b0;
   logic                  reset   = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_x_idle = 1'b0;
   logic                  req_y_idle = 1'b0;
   logic                  rsp_ready  = 1'b0;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;

   logic                  req_ready;
   logic                  rsp_valid;
   logic [TARGET_W-1:0]   rsp_target_x;
   logic [TARGET_W-1:0]   rsp_target_y;
   logic [POS_W-1:0]      rsp_point_number;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow of the block's registers and curve index
   logic [ORDER_W-1:0] order_setting = ORDER_RESET;
   logic [SCALE_W-1:0] scale_setting = SCALE_RESET;
   logic [POS_W-1:0]   next_curve_index = '0;

   point_type pending_points [$];
   int     mismatch_count = 0;
   int     quiet_cycles   = 0;
   logic [9:0] stall_tick = '0;

   // directed stimulus: extremes, busy axes, order clamping, index past the curve end
   scan_row_type directed_rows [0:24] = '{
      '{ROW_POLL,  TYPED_IN,   1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   FIRST_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b0, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b0, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b0, 1'b0, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_ORDER, 32'd1,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_SCALE, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_SCALE, 32'd255, NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_ORDER, 32'd15,  NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_ORDER, 32'd8,   NO_POINT},
      '{ROW_POLL,  FROM_MODEL, 1'b1, 1'b1, CSR_IDX_ORDER, 32'd0,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_ORDER, 32'd3,   NO_POINT},
      '{ROW_WRITE, FROM_MODEL, 1'b0, 1'b0, CSR_IDX_SCALE, 32'd5,   NO_POINT}
   };

   // register settings of the random phases, extremes included
   curve_setting_type phase_settings [0:9] = '{
      '{order: 4'd1,  scale: 8'd1},
      '{order: 4'd8,  scale: 8'd255},
      '{order: 4'd2,  scale: 8'd0},
      '{order: 4'd0,  scale: 8'd17},
      '{order: 4'd15, scale: 8'd3},
      '{order: 4'd4,  scale: 8'd128},
      '{order: 4'd5,  scale: 8'd200},
      '{order: 4'd1,  scale: 8'd255},
      '{order: 4'd6,  scale: 8'd1},
      '{order: 4'd3,  scale: 8'd5}
   };

   hilbert_scan_point_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_x_idle       (req_x_idle),
      .req_y_idle       (req_y_idle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target_x     (rsp_target_x),
      .rsp_target_y     (rsp_target_y),
      .rsp_point_number (rsp_point_number),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   // compute the next curve point from the shadow registers and advance the index
   task automatic next_curve_point(output point_type p);
      int unsigned ord;
      int unsigned mask;
      int unsigned walk;
      int unsigned gx;
      int unsigned gy;
      int unsigned side;
      int unsigned swap;
      int unsigned rx;
      int unsigned ry;
      ord = order_setting;
      if (ord < 1) ord = 1;
      if (ord > CURVE_ORDER_CAP) ord = CURVE_ORDER_CAP;
      mask = ((32'd1 << (2 * ord)) - 1) & 32'hFFFF;
      walk = next_curve_index & mask;
      p.n  = POS_W'(walk);
      gx = 0;
      gy = 0;
      for (int lvl = 0; lvl < ord; lvl++) begin
         side = 32'd1 << lvl;
         rx = (walk >> 1) & 1;
         ry = (walk ^ rx) & 1;
         // reflect and transpose the lower quadrants
         if (ry == 0) begin
            if (rx == 1) begin
               gx = side - 1 - gx;
               gy = side - 1 - gy;
            end
            swap = gx;
            gx   = gy;
            gy   = swap;
         end
         gx   = gx + side * rx;
         gy   = gy + side * ry;
         walk = walk >> 2;
      end
      p.x = TARGET_W'(gx * scale_setting);
      p.y = TARGET_W'(gy * scale_setting);
      next_curve_index = POS_W'((p.n + 1) & mask);
   endtask

   // hold one request until accepted; record its expected point if both axes are idle
   task automatic send_request(input logic xi, input logic yi, input row_check_type check,
                               input point_type typed);
      point_type p;
      req_valid  <= 1'b1;
      req_x_idle <= xi;
      req_y_idle <= yi;
      do @(posedge clock); while (!req_ready);
      if (xi && yi) begin
         next_curve_point(p);
         pending_points.push_back(check == TYPED_IN ? typed : p);
      end
   endtask

   // drop valid, wait for every expected point, then let the block settle
   task automatic settle_block(input int extra);
      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic write_register(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] kept;
      kept = (idx == CSR_IDX_ORDER) ? CSR_DATA_W'(value[ORDER_W-1:0])
                                    : CSR_DATA_W'(value[SCALE_W-1:0]);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_IDX_ORDER) order_setting = value[ORDER_W-1:0];
      else scale_setting = value[SCALE_W-1:0];
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== kept) begin
         $error("register %0d readback: expected %0h, actual %0h", idx, kept, prdata);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic xi;
      logic yi;
      int   polls;
      int   burst_left;
      bit   gapless;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle_block(SETTLE_CYCLES);
            write_register(directed_rows[i].reg_idx, directed_rows[i].value);
         end else begin
            send_request(directed_rows[i].x_idle, directed_rows[i].y_idle,
                         directed_rows[i].check, directed_rows[i].expected);
         end
      end

      // random phases: mostly both-idle polls, some busy ones, bursts and gaps
      foreach (phase_settings[ph]) begin
         settle_block(SETTLE_CYCLES);
         write_register(CSR_IDX_ORDER, CSR_DATA_W'(phase_settings[ph].order));
         write_register(CSR_IDX_SCALE, CSR_DATA_W'(phase_settings[ph].scale));
         gapless    = (ph % 4 == 3);
         polls      = 0;
         burst_left = $urandom_range(1, 12);
         while (polls < POLLS_PER_PHASE) begin
            xi = $urandom_range(0, 1);
            yi = $urandom_range(0, 1);
            if ($urandom_range(0, 4) != 0) begin
               xi = 1'b1;
               yi = 1'b1;
            end
            send_request(xi, yi, FROM_MODEL, NO_POINT);
            polls++;
            if (!gapless) begin
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  req_valid <= 1'b0;
                  repeat ($urandom_range(1, 10)) @(posedge clock);
               end
            end
         end
      end

      settle_block(DRAIN_CYCLES);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // receiver: cycle through always-ready, random, sparse and long-stall patterns
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      case (stall_tick[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_tick[2:0] == 3'd0);
         default: rsp_ready <= stall_tick[4];
      endcase
   end

   // compare each accepted result with the oldest expected point
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result: x %0d y %0d point %0d",
                   rsp_target_x, rsp_target_y, rsp_point_number);
            mismatch_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_target_x !== want.x) begin
               $error("target_x: expected %0d, actual %0d", want.x, rsp_target_x);
               mismatch_count++;
            end
            if (rsp_target_y !== want.y) begin
               $error("target_y: expected %0d, actual %0d", want.y, rsp_target_y);
               mismatch_count++;
            end
            if (rsp_point_number !== want.n) begin
               $error("point_number: expected %0d, actual %0d", want.n, rsp_point_number);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < STALL_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
rtl/core/hsp_pkg.sv
rtl/core/hsp_walk.sv
rtl/core/hsp_scale.sv
rtl/core/hilbert_scan_point_generator.sv
tb/tb_hilbert_scan_point_generator.sv
